>>> design/lqm_pkg.sv
// Package for the linked queue manager: field widths, action codes,
// the classified command beat and the back-end sequencer states.
// Used by every module of the block; depends on nothing.
package lqm_pkg;

  localparam int ACT_W  = 3;
  localparam int QID_W  = 3;
  localparam int ITEM_W = 6;

  localparam int NUM_ITEMS_DEF  = 64;
  localparam int NUM_QUEUES_DEF = 8;

  // Depth of the command queue between the front and the back end.
  localparam int CMD_DEPTH = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_APPEND     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PREPEND    = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP,
    OP_APPEND,
    OP_PREPEND,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              q_ok;
    logic [QID_W-1:0]  q;
    logic [QID_W-1:0]  o;
    logic [ITEM_W-1:0] item;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ_OTHER,
    BK_EXEC,
    BK_LINK
  } bk_state_t;

endpackage

>>> design/lqm_front.sv
// Front end of the linked queue manager: range checks and classifies an
// input beat into a command for the back end.
// Depends on lqm_pkg.
module lqm_front #(
  parameter int NUM_ITEMS  = lqm_pkg::NUM_ITEMS_DEF,
  parameter int NUM_QUEUES = lqm_pkg::NUM_QUEUES_DEF
) (
  input  logic [lqm_pkg::ACT_W-1:0]  action,
  input  logic [lqm_pkg::QID_W-1:0]  queue_id,
  input  logic [lqm_pkg::QID_W-1:0]  other_queue,
  input  logic [lqm_pkg::ITEM_W-1:0] item_index,
  output lqm_pkg::cmd_t              cmd
);

  logic q_ok;
  logic o_ok;
  logic item_ok;

  assign q_ok    = 32'(queue_id) < NUM_QUEUES;
  assign o_ok    = (32'(other_queue) < NUM_QUEUES) && (other_queue != queue_id);
  assign item_ok = 32'(item_index) < NUM_ITEMS;

  always_comb begin
    cmd.q_ok = q_ok;
    cmd.q    = queue_id;
    cmd.o    = other_queue;
    cmd.item = item_index;
    cmd.op   = lqm_pkg::OP_NOP;
    if (q_ok) begin
      unique case (action)
        lqm_pkg::ACT_PUSH_BACK:  cmd.op = item_ok ? lqm_pkg::OP_PUSH_BACK  : lqm_pkg::OP_NOP;
        lqm_pkg::ACT_PUSH_FRONT: cmd.op = item_ok ? lqm_pkg::OP_PUSH_FRONT : lqm_pkg::OP_NOP;
        lqm_pkg::ACT_POP_FRONT:  cmd.op = lqm_pkg::OP_POP;
        lqm_pkg::ACT_APPEND:     cmd.op = o_ok ? lqm_pkg::OP_APPEND  : lqm_pkg::OP_NOP;
        lqm_pkg::ACT_PREPEND:    cmd.op = o_ok ? lqm_pkg::OP_PREPEND : lqm_pkg::OP_NOP;
        default:                 cmd.op = lqm_pkg::OP_NOP;
      endcase
    end
  end

endmodule

>>> design/lqm_cmd_fifo.sv
// Short command queue between the front and the back end of the linked
// queue manager. Depends on lqm_pkg for the command type and depth.
module lqm_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lqm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lqm_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (lqm_pkg::CMD_DEPTH > 1) ? $clog2(lqm_pkg::CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(lqm_pkg::CMD_DEPTH + 1);

  lqm_pkg::cmd_t    entries [lqm_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(lqm_pkg::CMD_DEPTH);
  assign not_empty = count != '0;
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> design/lqm_back.sv
// Back end of the linked queue manager: head and tail tables, the shared
// next-link RAM, the command sequencer and the result register.
// Depends on lqm_pkg.
module lqm_back #(
  parameter int NUM_ITEMS  = lqm_pkg::NUM_ITEMS_DEF,
  parameter int NUM_QUEUES = lqm_pkg::NUM_QUEUES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  lqm_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [lqm_pkg::ITEM_W-1:0] popped_item,
  output logic                       popped_valid,
  output logic                       target_empty
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW = $clog2(NUM_ITEMS);
  localparam int LW = $clog2(NUM_ITEMS + 1);
  localparam int QX = QW + lqm_pkg::QID_W;
  localparam int LX = LW + lqm_pkg::ITEM_W;
  localparam logic [LW-1:0] LINK_NULL = LW'(NUM_ITEMS);

  lqm_pkg::bk_state_t state;
  lqm_pkg::bk_state_t state_next;

  logic [LW-1:0] head_link [NUM_QUEUES];
  logic [LW-1:0] tail_link [NUM_QUEUES];
  logic [LW-1:0] next_mem  [NUM_ITEMS];

  lqm_pkg::cmd_t cmd_r;
  logic [LW-1:0] hq;
  logic [LW-1:0] tq;
  logic [LW-1:0] ho;
  logic [LW-1:0] to;
  logic [LW-1:0] rd_data;

  logic [QX-1:0] q_in_x;
  logic [QX-1:0] q_x;
  logic [QX-1:0] o_x;
  logic [QW-1:0] q_in_idx;
  logic [QW-1:0] q_idx;
  logic [QW-1:0] o_idx;
  logic [LX-1:0] item_x;
  logic [LW-1:0] item_link;
  logic [LX-1:0] hq_x;

  logic          out_free;
  logic          fire;
  logic          need_link;
  logic          mem_re;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [LW-1:0] mem_wd;
  logic [LW-1:0] hq_new;
  logic [LW-1:0] tq_new;
  logic          clr_other;
  logic [lqm_pkg::ITEM_W-1:0] res_item;
  logic          res_valid;
  logic          res_empty;

  function automatic logic is_null(input logic [LW-1:0] v);
    return v >= LINK_NULL;
  endfunction

  assign q_in_x    = {{QW{1'b0}}, cmd.q};
  assign q_in_idx  = q_in_x[QW-1:0];
  assign q_x       = {{QW{1'b0}}, cmd_r.q};
  assign q_idx     = q_x[QW-1:0];
  assign o_x       = {{QW{1'b0}}, cmd_r.o};
  assign o_idx     = o_x[QW-1:0];
  assign item_x    = {{LW{1'b0}}, cmd_r.item};
  assign item_link = item_x[LW-1:0];
  assign hq_x      = {{lqm_pkg::ITEM_W{1'b0}}, hq};

  assign out_free  = !result_valid || result_ready;
  assign need_link = (cmd_r.op == lqm_pkg::OP_PUSH_BACK) && !is_null(tq);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lqm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lqm_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          state_next = lqm_pkg::BK_READ_OTHER;
        end
      end
      lqm_pkg::BK_READ_OTHER: state_next = lqm_pkg::BK_EXEC;
      lqm_pkg::BK_EXEC: begin
        if (out_free) begin
          state_next = need_link ? lqm_pkg::BK_LINK : lqm_pkg::BK_IDLE;
        end
      end
      lqm_pkg::BK_LINK: state_next = lqm_pkg::BK_IDLE;
      default:          state_next = lqm_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs and the update each command makes.
  always_comb begin
    cmd_pop   = (state == lqm_pkg::BK_IDLE) && cmd_valid;
    mem_re    = state == lqm_pkg::BK_READ_OTHER;
    fire      = (state == lqm_pkg::BK_EXEC) && out_free;
    mem_we    = 1'b0;
    mem_wa    = item_link[IW-1:0];
    mem_wd    = LINK_NULL;
    hq_new    = hq;
    tq_new    = tq;
    clr_other = 1'b0;
    res_item  = '0;
    res_valid = 1'b0;
    if (state == lqm_pkg::BK_LINK) begin
      mem_we = 1'b1;
      mem_wa = tq[IW-1:0];
      mem_wd = item_link;
    end
    if (state == lqm_pkg::BK_EXEC) begin
      unique case (cmd_r.op)
        lqm_pkg::OP_PUSH_BACK: begin
          mem_we = fire;
          if (is_null(tq)) begin
            hq_new = item_link;
          end
          tq_new = item_link;
        end
        lqm_pkg::OP_PUSH_FRONT: begin
          mem_we = fire;
          mem_wd = is_null(hq) ? LINK_NULL : hq;
          hq_new = item_link;
          if (is_null(tq)) begin
            tq_new = item_link;
          end
        end
        lqm_pkg::OP_POP: begin
          if (!is_null(hq)) begin
            hq_new    = is_null(rd_data) ? LINK_NULL : rd_data;
            tq_new    = is_null(rd_data) ? LINK_NULL : tq;
            res_item  = hq_x[lqm_pkg::ITEM_W-1:0];
            res_valid = 1'b1;
          end
        end
        lqm_pkg::OP_APPEND: begin
          if (!is_null(ho)) begin
            clr_other = 1'b1;
            if (is_null(hq)) begin
              hq_new = ho;
            end else if (!is_null(tq)) begin
              mem_we = fire;
              mem_wa = tq[IW-1:0];
              mem_wd = ho;
            end
            tq_new = is_null(to) ? LINK_NULL : to;
          end
        end
        lqm_pkg::OP_PREPEND: begin
          if (!is_null(ho)) begin
            clr_other = 1'b1;
            mem_we    = fire && !is_null(to);
            mem_wa    = to[IW-1:0];
            mem_wd    = is_null(hq) ? LINK_NULL : hq;
            hq_new    = ho;
            if (is_null(tq)) begin
              tq_new = is_null(to) ? LINK_NULL : to;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_empty = cmd_r.q_ok ? is_null(hq_new) : 1'b1;
  end

  // Operand capture: target entries first, then the other queue's entries.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
      hq    <= head_link[q_in_idx];
      tq    <= tail_link[q_in_idx];
    end
    if (state == lqm_pkg::BK_READ_OTHER) begin
      ho <= head_link[o_idx];
      to <= tail_link[o_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_link[i] <= LINK_NULL;
        tail_link[i] <= LINK_NULL;
      end
    end else if (fire && cmd_r.op != lqm_pkg::OP_NOP) begin
      head_link[q_idx] <= hq_new;
      tail_link[q_idx] <= tq_new;
      if (clr_other) begin
        head_link[o_idx] <= LINK_NULL;
        tail_link[o_idx] <= LINK_NULL;
      end
    end
  end

  // Next-link RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= next_mem[hq[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      popped_item  <= res_item;
      popped_valid <= res_valid;
      target_empty <= res_empty;
    end
  end

endmodule

>>> design/linked_queue_manager_top.sv
// Top level of the linked queue manager: front end, command queue and
// back end. Depends on lqm_pkg, lqm_front, lqm_cmd_fifo and lqm_back.
//
//   Channel   Handshake                    Payload
//   item      item_valid / item_ready      action, queue_id, other_queue, item_index
//   result    result_valid / result_ready  popped_item, popped_valid, target_empty
//
// The front end checks the queue and item numbers of each beat and turns
// it into one command; a two-entry command queue lets it keep taking beats
// while the back end works or the result register waits to be taken.
// The back end runs one command at a time: the idle state reads the
// target's head and tail, BK_READ_OTHER reads the other queue's entries and
// the next-link RAM at the target's head, and BK_EXEC commits the update
// and loads the result register. A push to the back of a non-empty queue
// also passes through BK_LINK, since its second link write goes through
// the single RAM write port.
// Reset (synchronous, active high) empties every queue at once; the
// next-link RAM is not cleared and needs no clearing pass.
// A stalled result holds the back end in its commit cycle, and the item
// side stalls only when the command queue is full.
module linked_queue_manager_top #(
  parameter int NUM_ITEMS  = lqm_pkg::NUM_ITEMS_DEF,
  parameter int NUM_QUEUES = lqm_pkg::NUM_QUEUES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [lqm_pkg::ACT_W-1:0]  action,
  input  logic [lqm_pkg::QID_W-1:0]  queue_id,
  input  logic [lqm_pkg::QID_W-1:0]  other_queue,
  input  logic [lqm_pkg::ITEM_W-1:0] item_index,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [lqm_pkg::ITEM_W-1:0] popped_item,
  output logic                       popped_valid,
  output logic                       target_empty
);

  lqm_pkg::cmd_t front_cmd;
  lqm_pkg::cmd_t queued_cmd;
  logic          fifo_full;
  logic          fifo_not_empty;
  logic          cmd_pop;

  // A beat is taken whenever the command queue has room.
  assign item_ready = !fifo_full;

  lqm_front #(
    .NUM_ITEMS  (NUM_ITEMS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .action      (action),
    .queue_id    (queue_id),
    .other_queue (other_queue),
    .item_index  (item_index),
    .cmd         (front_cmd)
  );

  lqm_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && item_ready),
    .push_cmd  (front_cmd),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .not_empty (fifo_not_empty),
    .head_cmd  (queued_cmd)
  );

  lqm_back #(
    .NUM_ITEMS  (NUM_ITEMS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (fifo_not_empty),
    .cmd          (queued_cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .popped_item  (popped_item),
    .popped_valid (popped_valid),
    .target_empty (target_empty)
  );

endmodule

>>> design/lqm_checker.sv
// Port-level checks for the linked queue manager, bound to the top level.
// Depends on lqm_pkg for field widths.
module lqm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_ready,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [lqm_pkg::ITEM_W-1:0] popped_item,
  input logic                       popped_valid,
  input logic                       target_empty
);

  // A result left untaken holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(popped_item) && $stable(popped_valid)
      && $stable(target_empty))
    else $error("stalled result changed");

  // No item without a successful pop.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !popped_valid |-> popped_item == '0)
    else $error("popped item nonzero without a pop");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result pending after reset");

  // Reset empties the command queue, so the item side is ready right away.
  assert property (@(posedge clk)
    $past(rst) |-> item_ready)
    else $error("item side not ready after reset");

endmodule

bind linked_queue_manager_top lqm_checker u_lqm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .popped_item  (popped_item),
  .popped_valid (popped_valid),
  .target_empty (target_empty)
);
